### rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// Trilinear volume sampler package
// Shared widths, parameter defaults and configuration register codes.
// ----------------------------------------------------------------------------
package tvs_pkg;

	localparam int MAX_AXIS_CELLS_DEF = 32;
	localparam int CELL_CAPACITY_DEF  = 32768;
	localparam int FRACTION_BITS_DEF  = 16;

	localparam int POS_W     = 32;
	localparam int DENS_W    = 16;
	localparam int ADDR_W    = 15;
	localparam int DIM_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_INV_VOXEL,
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT,
		REG_GRID_DEPTH,
		REG_SAMPLING_EN
	} cfg_reg_t;

endpackage

### rtl/tvs_axis.sv
// ----------------------------------------------------------------------------
// Axis mapper
// Three stages: offset from origin, scale by the reciprocal voxel size, then
// bounds check and neighbor cell selection for one coordinate axis.
// ----------------------------------------------------------------------------
module tvs_axis #(
	parameter int MAX_AXIS_CELLS = tvs_pkg::MAX_AXIS_CELLS_DEF,
	parameter int FRACTION_BITS  = tvs_pkg::FRACTION_BITS_DEF,
	localparam int DW = $clog2(MAX_AXIS_CELLS + 1),
	localparam int CW = $clog2(MAX_AXIS_CELLS)
) (
	input  logic                               clk,
	input  logic                               adv,
	input  logic signed [tvs_pkg::POS_W-1:0]   pos,
	input  logic signed [tvs_pkg::POS_W-1:0]   origin,
	input  logic        [tvs_pkg::POS_W-1:0]   inv,
	input  logic        [DW-1:0]               dim,
	output logic        [CW-1:0]               cell0_s3,
	output logic        [CW-1:0]               cell1_s3,
	output logic        [FRACTION_BITS-1:0]    frac_s3,
	output logic                               inside_s3
);
	import tvs_pkg::*;

	logic [POS_W:0]     diff;
	logic [POS_W:0]     ndiff;
	logic [POS_W-1:0]   mag_s1;
	logic               neg_s1;
	logic [2*POS_W-1:0] prod_s2;
	logic               neg_s2;
	logic [POS_W-1:0]   hi;
	logic [DW-1:0]      nxt;
	logic [CW-1:0]      c0;

	always_comb begin
		diff  = {pos[POS_W-1], pos} - {origin[POS_W-1], origin};
		ndiff = -diff;
		hi    = prod_s2[2*POS_W-1:POS_W];
		c0    = hi[CW-1:0];
		nxt   = DW'(c0) + DW'(1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1    <= diff[POS_W] ? ndiff[POS_W-1:0] : diff[POS_W-1:0];
			neg_s1    <= diff[POS_W];
			prod_s2   <= (2*POS_W)'(mag_s1) * (2*POS_W)'(inv);
			neg_s2    <= neg_s1;
			inside_s3 <= !(neg_s2 && (prod_s2 != '0)) && (hi < POS_W'(dim));
			cell0_s3  <= c0;
			cell1_s3  <= (nxt < dim) ? nxt[CW-1:0] : c0;
			frac_s3   <= prod_s2[POS_W-1 -: FRACTION_BITS];
		end
	end

endmodule

### rtl/trilinear_volume_sampler.sv
// ----------------------------------------------------------------------------
// Trilinear volume sampler
// Voxel grid of densities and solid marks with a pipelined trilinear sampler.
//
//   Channel   Signals                         Beat
//   in        in_valid, in_stall, fields      one cell write or one sample
//   out       out_valid, out_stall, fields    one sampled density
//   cfg       cfg_we, cfg_index, cfg_data     one register write
//
// One beat is taken each cycle while in_stall is low; a sample result passes
// registers s1 through s9 before it shows on out_valid.
// The grid is held in eight copies of one memory, one per neighbor read port.
// After reset a clearing pass zeroes every cell address in turn while
// in_stall is high. out_stall with out_valid high freezes the whole pipeline.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler #(
	parameter int MAX_AXIS_CELLS = tvs_pkg::MAX_AXIS_CELLS_DEF,
	parameter int CELL_CAPACITY  = tvs_pkg::CELL_CAPACITY_DEF,
	parameter int FRACTION_BITS  = tvs_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tvs_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [tvs_pkg::ADDR_W-1:0]          cell_address,
	input  logic [tvs_pkg::DENS_W-1:0]          cell_density,
	input  logic                                cell_solid,
	input  logic signed [tvs_pkg::POS_W-1:0]    pos_x,
	input  logic signed [tvs_pkg::POS_W-1:0]    pos_y,
	input  logic signed [tvs_pkg::POS_W-1:0]    pos_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tvs_pkg::DENS_W-1:0]          sampled_density,
	output logic                                inside_grid
);
	import tvs_pkg::*;

	localparam int DW = $clog2(MAX_AXIS_CELLS + 1);
	localparam int CW = $clog2(MAX_AXIS_CELLS);
	localparam int RW = 2 * DW;
	localparam int IW = 3 * DW;
	localparam int AW = $clog2(CELL_CAPACITY);
	localparam int F  = FRACTION_BITS;
	localparam int DIM_RST = (MAX_AXIS_CELLS < 32) ? MAX_AXIS_CELLS : 32;

	typedef struct packed {
		logic               smp;
		logic               wok;
		logic [AW-1:0]      waddr;
		logic [DENS_W-1:0]  wdens;
		logic               wsolid;
	} item_t;

	function automatic logic [DENS_W-1:0] lerp(input logic [DENS_W-1:0] a,
		input logic [DENS_W-1:0] b, input logic [F-1:0] f);
		logic [F:0]        one_m;
		logic [F+DENS_W:0] s;
		one_m = {1'b1, {F{1'b0}}} - {1'b0, f};
		s = (F+DENS_W+1)'(a) * (F+DENS_W+1)'(one_m) +
			(F+DENS_W+1)'(b) * (F+DENS_W+1)'(f);
		return s[F+DENS_W-1:F];
	endfunction

	logic signed [POS_W-1:0] org_x_q, org_y_q, org_z_q;
	logic [POS_W-1:0]        inv_q;
	logic [DW-1:0]           w_q, h_q, d_q;
	logic                    en_q;
	logic [DW-1:0]           cfg_dim;

	logic                    clr_busy_q;
	logic [AW-1:0]           clr_q;
	logic                    adv;

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	item_t                   itm_s1, itm_s2, itm_s3, itm_s4, itm_s5;
	logic [31:0]             a32;

	logic [CW-1:0]           x0_s3, x1_s3, y0_s3, y1_s3, z0_s3, z1_s3;
	logic [F-1:0]            fx_s3, fy_s3, fz_s3;
	logic                    ix_s3, iy_s3, iz_s3;

	logic [CW-1:0]           x0_s4, x1_s4;
	logic [F-1:0]            fx_s4, fy_s4, fz_s4, fx_s5, fy_s5, fz_s5;
	logic [F-1:0]            fx_s6, fy_s6, fz_s6, fy_s7, fz_s7, fz_s8;
	logic                    ins_s4, ins_s5, ins_s6, ins_s7, ins_s8, ins_s9;
	logic [RW-1:0]           row_s4 [4];
	logic [AW-1:0]           addr_s5 [8];
	logic                    ok_s5 [8];
	logic                    ok_s6 [8];
	logic [DENS_W:0]         rd_s6 [8];
	logic [DENS_W-1:0]       c_s7 [4];
	logic [DENS_W-1:0]       c_s8 [2];
	logic [DENS_W-1:0]       dens_s9;

	logic                    we;
	logic [AW-1:0]           wa;
	logic [DENS_W:0]         wd;

	assign adv      = !(v_s9 && out_stall);
	assign in_stall = clr_busy_q || !adv;
	assign cfg_dim  = (int'(cfg_data[DIM_W-1:0]) > MAX_AXIS_CELLS) ?
		DW'(MAX_AXIS_CELLS) : DW'(cfg_data[DIM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			inv_q   <= POS_W'(65536);
			w_q     <= DW'(DIM_RST);
			h_q     <= DW'(DIM_RST);
			d_q     <= DW'(DIM_RST);
			en_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:    org_x_q <= cfg_data;
				REG_ORIGIN_Y:    org_y_q <= cfg_data;
				REG_ORIGIN_Z:    org_z_q <= cfg_data;
				REG_INV_VOXEL:   inv_q   <= cfg_data;
				REG_GRID_WIDTH:  w_q     <= cfg_dim;
				REG_GRID_HEIGHT: h_q     <= cfg_dim;
				REG_GRID_DEPTH:  d_q     <= cfg_dim;
				REG_SAMPLING_EN: en_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(CELL_CAPACITY - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && !clr_busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5 && itm_s5.smp;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign a32 = 32'(cell_address);

	tvs_axis #(.MAX_AXIS_CELLS(MAX_AXIS_CELLS), .FRACTION_BITS(F)) u_axis_x (
		.clk(clk), .adv(adv), .pos(pos_x), .origin(org_x_q), .inv(inv_q), .dim(w_q),
		.cell0_s3(x0_s3), .cell1_s3(x1_s3), .frac_s3(fx_s3), .inside_s3(ix_s3)
	);
	tvs_axis #(.MAX_AXIS_CELLS(MAX_AXIS_CELLS), .FRACTION_BITS(F)) u_axis_y (
		.clk(clk), .adv(adv), .pos(pos_y), .origin(org_y_q), .inv(inv_q), .dim(h_q),
		.cell0_s3(y0_s3), .cell1_s3(y1_s3), .frac_s3(fy_s3), .inside_s3(iy_s3)
	);
	tvs_axis #(.MAX_AXIS_CELLS(MAX_AXIS_CELLS), .FRACTION_BITS(F)) u_axis_z (
		.clk(clk), .adv(adv), .pos(pos_z), .origin(org_z_q), .inv(inv_q), .dim(d_q),
		.cell0_s3(z0_s3), .cell1_s3(z1_s3), .frac_s3(fz_s3), .inside_s3(iz_s3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			itm_s1.smp    <= mode;
			itm_s1.wok    <= a32 < 32'(CELL_CAPACITY);
			itm_s1.waddr  <= a32[AW-1:0];
			itm_s1.wdens  <= cell_density;
			itm_s1.wsolid <= cell_solid;
			itm_s2 <= itm_s1;
			itm_s3 <= itm_s2;
			itm_s4 <= itm_s3;
			itm_s5 <= itm_s4;

			x0_s4  <= x0_s3;
			x1_s4  <= x1_s3;
			fx_s4  <= fx_s3;
			fy_s4  <= fy_s3;
			fz_s4  <= fz_s3;
			ins_s4 <= en_q && ix_s3 && iy_s3 && iz_s3;
			for (int j = 0; j < 4; j++) begin
				row_s4[j] <= RW'(j[0] ? y1_s3 : y0_s3) +
					RW'(h_q) * RW'(j[1] ? z1_s3 : z0_s3);
			end

			fx_s5  <= fx_s4;
			fy_s5  <= fy_s4;
			fz_s5  <= fz_s4;
			ins_s5 <= ins_s4;
			for (int k = 0; k < 8; k++) begin
				logic [31:0] idx32;
				idx32 = 32'(IW'(k[0] ? x1_s4 : x0_s4) + IW'(w_q) * IW'(row_s4[k / 2]));
				ok_s5[k]   <= idx32 < 32'(CELL_CAPACITY);
				addr_s5[k] <= idx32[AW-1:0];
			end

			fx_s6  <= fx_s5;
			fy_s6  <= fy_s5;
			fz_s6  <= fz_s5;
			ins_s6 <= ins_s5;
			ok_s6  <= ok_s5;

			for (int j = 0; j < 4; j++) begin
				c_s7[j] <= lerp(
					(ok_s6[2*j]   && !rd_s6[2*j][DENS_W])   ? rd_s6[2*j][DENS_W-1:0]   : '0,
					(ok_s6[2*j+1] && !rd_s6[2*j+1][DENS_W]) ? rd_s6[2*j+1][DENS_W-1:0] : '0,
					fx_s6);
			end
			fy_s7  <= fy_s6;
			fz_s7  <= fz_s6;
			ins_s7 <= ins_s6;

			c_s8[0] <= lerp(c_s7[0], c_s7[1], fy_s7);
			c_s8[1] <= lerp(c_s7[2], c_s7[3], fy_s7);
			fz_s8   <= fz_s7;
			ins_s8  <= ins_s7;

			dens_s9 <= ins_s8 ? lerp(c_s8[0], c_s8[1], fz_s8) : '0;
			ins_s9  <= ins_s8;
		end
	end

	assign we = clr_busy_q || (adv && v_s5 && !itm_s5.smp && itm_s5.wok);
	assign wa = clr_busy_q ? clr_q : itm_s5.waddr;
	assign wd = clr_busy_q ? '0 : {itm_s5.wsolid, itm_s5.wdens};

	for (genvar g = 0; g < 8; g++) begin : g_copy
		logic [DENS_W:0] mem [CELL_CAPACITY];

		always_ff @(posedge clk) begin
			if (we) begin
				mem[wa] <= wd;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_s6[g] <= mem[addr_s5[g]];
			end
		end
	end

	assign out_valid       = v_s9;
	assign sampled_density = dens_s9;
	assign inside_grid     = ins_s9;

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> in_stall)
		else $error("Input taken during the clearing pass.");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s5 && !v_s9)
		else $error("Pipeline busy during the clearing pass.");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_grid |-> sampled_density == '0)
		else $error("Outside sample carries a nonzero density.");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v_s9 && $stable(dens_s9) && $stable(ins_s9))
		else $error("Pipeline moved while stalled.");

endmodule
